// ===== rtl/core/carryless_range_encoder_macros.svh =====
// Assertion macros used by the range encoder checker.
`ifndef CARRYLESS_RANGE_ENCODER_MACROS_SVH
`define CARRYLESS_RANGE_ENCODER_MACROS_SVH

// Next-cycle implication, off while reset is high.
`define CRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range encoder port check failed");

// Next-cycle implication, also checked across reset.
`define CRE_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("range encoder reset check failed");

`endif

// ===== rtl/core/cre_pkg.sv =====
// Types and constants of the carryless range encoder.
`timescale 1ns / 1ps
package cre_pkg;

  localparam int unsigned ProbBits = 14;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned MaxEmit  = 4;

  typedef enum logic [1:0] {
    CMD_INTERVAL = 2'd0,
    CMD_BIT0     = 2'd1,
    CMD_BIT1     = 2'd2,
    CMD_FLUSH    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] start_req;
    logic [15:0] size;
    logic [15:0] total;
    logic [13:0] bit_prob;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/cre_div.sv =====
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor.
`timescale 1ns / 1ps
module cre_div
  import cre_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CntW = $clog2(DivSteps);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [15:0]     rem;
  logic [31:0]     quo;
  logic [15:0]     divisor;
  logic            done;
  logic [16:0]     rem_sh;
  logic [16:0]     diff;
  logic            ge;

  assign rem_sh = {rem, quo[31]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
      end else if (busy) begin
        quo <= {quo[30:0], ge};
        rem <= ge ? diff[15:0] : rem_sh[15:0];
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/core/carryless_range_encoder.sv =====
// Carryless 32-bit range encoder top level.
// One command is taken at a time and cmd_ready stays low until its last byte
// sits in the output register. An interval command runs the 32-step divider,
// one quotient bit per cycle, then three multiply/update steps on one shared
// 32x16 multiplier (MUL_LO, MUL_RG, SET_RG) and normalizes, emitting up to
// four bytes. A bit command skips the divider. A flush emits the four bytes
// of low, one per cycle while the output register is free; output stalls
// also hold the normalize step.
`timescale 1ns / 1ps
module carryless_range_encoder
  import cre_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  in_t  cmd_data,
  output logic byte_valid,
  input  logic byte_ready,
  output out_t byte_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_LO,
    ST_MUL_RG,
    ST_SET_RG,
    ST_NORM,
    ST_FLUSH
  } state_t;

  state_t      state;
  logic [31:0] low;
  logic [31:0] range;
  logic [31:0] q;
  logic [31:0] prod;
  logic [15:0] a_start;
  logic [15:0] a_size;
  logic [2:0]  n;
  logic [7:0]  pend;
  logic        pend_valid;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        accept;
  logic        out_free;
  logic        byte_load;
  logic [15:0] mul_b;
  logic [47:0] mul_full;
  logic [31:0] sum;
  logic [31:0] diffx;
  logic [31:0] neg_low;
  logic        settled;
  logic        emit;
  logic [31:0] range_eff;
  logic [14:0] prob_one;

  assign accept    = cmd_valid && cmd_ready;
  assign out_free  = !byte_valid || byte_ready;
  assign byte_load = out_free && (((state == ST_NORM) && pend_valid) || (state == ST_FLUSH));

  assign div_req.start    = accept && (cmd_data.cmd == CMD_INTERVAL);
  assign div_req.dividend = range;
  assign div_req.divisor  = (cmd_data.total == 16'd0) ? 16'd1 : cmd_data.total;

  cre_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign mul_b    = (state == ST_MUL_LO) ? a_start : a_size;
  assign mul_full = q * mul_b;

  assign sum       = low + range;
  assign diffx     = low ^ sum;
  assign neg_low   = 32'd0 - low;
  assign settled   = diffx[31:24] == 8'd0;
  assign emit      = (n < 3'(MaxEmit)) && (settled || (range[31:15] == 17'd0));
  assign range_eff = settled ? range : {17'd0, neg_low[14:0]};
  assign prob_one  = 15'((1 << ProbBits)) - {1'b0, cmd_data.bit_prob};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cmd_ready  <= 1'b1;
      byte_valid <= 1'b0;
      pend_valid <= 1'b0;
      low        <= '0;
      range      <= '1;
      n          <= '0;
    end else begin
      if (byte_load) begin
        byte_valid <= 1'b1;
      end else if (byte_valid && byte_ready) begin
        byte_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_ready <= 1'b0;
            n         <= '0;
            case (cmd_data.cmd)
              CMD_INTERVAL: begin
                a_start <= cmd_data.start_req;
                a_size  <= cmd_data.size;
                state   <= ST_DIV;
              end
              CMD_BIT0: begin
                q       <= {14'd0, range[31:14]};
                a_start <= '0;
                a_size  <= {2'd0, cmd_data.bit_prob};
                state   <= ST_MUL_LO;
              end
              CMD_BIT1: begin
                q       <= {14'd0, range[31:14]};
                a_start <= {2'd0, cmd_data.bit_prob};
                a_size  <= {1'b0, prob_one};
                state   <= ST_MUL_LO;
              end
              default: begin
                state <= ST_FLUSH;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            q     <= div_rsp.quotient;
            state <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          prod  <= mul_full[31:0];
          state <= ST_MUL_RG;
        end
        ST_MUL_RG: begin
          low   <= low + prod;
          prod  <= mul_full[31:0];
          state <= ST_SET_RG;
        end
        ST_SET_RG: begin
          range      <= prod;
          pend_valid <= 1'b0;
          state      <= ST_NORM;
        end
        ST_NORM: begin
          if (emit) begin
            if (!pend_valid || out_free) begin
              if (pend_valid) begin
                byte_data.out_byte  <= pend;
                byte_data.last      <= 1'b0;
              end
              pend       <= low[31:24];
              pend_valid <= 1'b1;
              low        <= {low[23:0], 8'd0};
              range      <= {range_eff[23:0], 8'd0};
              n          <= n + 1'b1;
            end
          end else if (!pend_valid) begin
            cmd_ready <= 1'b1;
            state     <= ST_IDLE;
          end else if (out_free) begin
            byte_data.out_byte <= pend;
            byte_data.last     <= 1'b1;
            pend_valid         <= 1'b0;
            cmd_ready          <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            byte_data.out_byte <= low[31:24];
            byte_data.last     <= (n == 3'(MaxEmit - 1));
            low                <= {low[23:0], 8'd0};
            n                  <= n + 1'b1;
            if (n == 3'(MaxEmit - 1)) begin
              cmd_ready <= 1'b1;
              state     <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/cre_checker.sv =====
// Port-level checks of the range encoder and their binding.
`timescale 1ns / 1ps
`include "carryless_range_encoder_macros.svh"
module cre_checker
  import cre_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input in_t  cmd_data,
  input logic byte_valid,
  input logic byte_ready,
  input out_t byte_data
);

  logic flush_acc;

  assign flush_acc = cmd_valid && cmd_ready && (cmd_data.cmd == CMD_FLUSH);

  `CRE_ASSERT_RST(a_reset_idle, rst, cmd_ready && !byte_valid)
  `CRE_ASSERT_NEXT(a_byte_hold, byte_valid && !byte_ready, byte_valid && $stable(byte_data))
  `CRE_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready, !cmd_ready)
  `CRE_ASSERT_NEXT(a_flush_four, flush_acc, !cmd_ready [*4])

endmodule

bind carryless_range_encoder cre_checker u_chk (.*);
